// ===== hw/rtl/lbp_pkg.sv =====
`timescale 1ns / 1ps

package lbp_pkg;

    // Field widths fixed by the stream format.
    localparam int PIXEL_W      = 8;
    localparam int CODE_W       = 8;
    localparam int LINE_WIDTH_W = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int WINDOW_COLS  = 6;

    // Register map of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNIFORM_MODE = 2'd1;

    // Register values after reset.
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET   = 12'd640;
    localparam logic                    UNIFORM_MODE_RESET = 1'b1;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
    } lbp_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              row_end;
    } lbp_out_t;

    // Two columns back (0..2) and one column back (3..5), top to bottom.
    typedef logic [WINDOW_COLS-1:0][PIXEL_W-1:0] window_t;

    typedef logic [255:0][CODE_W-1:0] rank_table_t;

    // Patterns with at most two circular transitions get ranks 1..58 in
    // ascending pattern order; all other patterns map to zero.
    function automatic rank_table_t build_rank_table();
        rank_table_t table_q;
        int          rank;
        int          p;
        logic [7:0]  pat;
        logic [7:0]  diff;
        rank = 1;
        for (p = 0; p < 256; p++) begin
            pat  = 8'(p);
            diff = pat ^ {pat[0], pat[7:1]};
            if ($countones(diff) <= 2) begin
                table_q[p] = CODE_W'(rank);
                rank       = rank + 1;
            end else begin
                table_q[p] = '0;
            end
        end
        return table_q;
    endfunction

    localparam rank_table_t RANK_TABLE = build_rank_table();

endpackage

// ===== hw/rtl/lbp_line_buffer.sv =====
`timescale 1ns / 1ps

module lbp_line_buffer
    import lbp_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [2*PIXEL_W-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [2*PIXEL_W-1:0] wr_data
);

    // Each entry holds the older row in the upper byte and the newer row below.
    logic [2*PIXEL_W-1:0] mem [DEPTH];
    logic [2*PIXEL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same address in the same cycle is
    // forwarded so the reader sees the new contents.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lbp_pattern_unit.sv =====
`timescale 1ns / 1ps

module lbp_pattern_unit
    import lbp_pkg::*;
(
    input  window_t            window,
    input  logic [PIXEL_W-1:0] top_right,
    input  logic [PIXEL_W-1:0] right,
    input  logic [PIXEL_W-1:0] bottom_right,
    input  logic               uniform_mode,
    output logic [CODE_W-1:0]  code
);

    logic [PIXEL_W-1:0] centre;
    logic [7:0][PIXEL_W-1:0] nb;
    logic [7:0] pattern;

    // Neighbors run clockwise from top-left.
    always_comb begin
        centre = window[4];
        nb[0]  = window[0];
        nb[1]  = window[3];
        nb[2]  = top_right;
        nb[3]  = right;
        nb[4]  = bottom_right;
        nb[5]  = window[5];
        nb[6]  = window[2];
        nb[7]  = window[1];
        for (int k = 0; k < 8; k++) begin
            pattern[k] = (nb[k] >= centre);
        end
    end

    // Raw pattern or its uniform label.
    assign code = uniform_mode ? RANK_TABLE[pattern] : pattern;

endmodule

// ===== hw/rtl/lbp_3x3_uniform_coder.sv =====
`timescale 1ns / 1ps

// 3x3 local binary pattern coder. Pixels stream in raster order, one per
// transfer, and the block accepts one pixel every clock cycle when the result
// side is not stalled. Each result is registered in the output register when
// the pixel that completes its neighborhood moves on from the input stage,
// which holds it during the registered read of the line buffer and while the
// result side stalls. A result describes the pixel one row up and one column
// left of the arriving pixel, so the first two rows and the first two columns
// of each frame give no result, and row_end flags the last result of each row.
// Assert frame_start on the first pixel of a frame. line_width (register 0) is
// clamped to 3..MAX_WIDTH; uniform_mode (register 1) selects the raw 8-bit
// pattern (0) or the 59-level uniform label (1). Write configuration only
// while the stream is idle. The line buffer is not cleared after reset; the
// first two rows of a frame fill it.
module lbp_3x3_uniform_coder
    import lbp_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lbp_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lbp_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW0 > LINE_WIDTH_W) ? WW0 : LINE_WIDTH_W;

    // Configuration registers.
    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic                    uniform_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RESET;
            uniform_mode_reg <= UNIFORM_MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LINE_WIDTH: begin
                    line_width_reg <= cfg_data[LINE_WIDTH_W-1:0];
                end
                REG_UNIFORM_MODE: begin
                    uniform_mode_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective width, clamped to the supported range.
    logic [EW-1:0] width_ext;
    logic [EW-1:0] eff_width;

    always_comb begin
        width_ext = EW'(line_width_reg);
        if (width_ext < EW'(3)) begin
            eff_width = EW'(3);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
    end

    // Handshake control.
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s1_advance;
    logic s_accept;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // Column and row position of the arriving pixel.
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [1:0]    rows_seen_reg, rows_seen_next;
    logic [CW-1:0] col_base, col_in;
    logic [1:0]    rows_base, rows_in;
    logic          produce_in;
    logic          row_end_in;

    always_comb begin
        col_base  = column_count_reg;
        rows_base = rows_seen_reg;
        if (s_data.frame_start) begin
            col_base  = '0;
            rows_base = '0;
        end
        col_in  = col_base;
        rows_in = rows_base;
        if (EW'(col_base) >= eff_width) begin
            col_in = '0;
            if (rows_base < 2'd2) begin
                rows_in = rows_base + 2'd1;
            end
        end
        produce_in = (rows_in == 2'd2) && (col_in >= CW'(2));
        row_end_in = (EW'(col_in) == (eff_width - EW'(1)));
        column_count_next = col_in + CW'(1);
        rows_seen_next    = rows_in;
        if ((EW'(col_in) + EW'(1)) >= eff_width) begin
            column_count_next = '0;
            if (rows_in < 2'd2) begin
                rows_seen_next = rows_in + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            rows_seen_reg    <= '0;
        end else if (s_accept) begin
            column_count_reg <= column_count_next;
            rows_seen_reg    <= rows_seen_next;
        end
    end

    // Input stage: holds the pixel while the line buffer read completes.
    logic               s1_valid_next;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [CW-1:0]      s1_col_reg;
    logic               s1_produce_reg;
    logic               s1_row_end_reg;

    assign s1_valid_next = s_accept ? 1'b1 : (s1_valid_reg && !s1_advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg   <= s_data.pixel;
            s1_col_reg     <= col_in;
            s1_produce_reg <= produce_in;
            s1_row_end_reg <= row_end_in;
        end
    end

    // Line buffer: read at acceptance, written back when the pixel moves on.
    logic [2*PIXEL_W-1:0] lb_rd_data;
    logic [PIXEL_W-1:0]   top_right;
    logic [PIXEL_W-1:0]   right;

    lbp_line_buffer #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CW)
    ) u_line_buffer (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_in),
        .rd_data (lb_rd_data),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data ({right, s1_pixel_reg})
    );

    assign top_right = lb_rd_data[2*PIXEL_W-1:PIXEL_W];
    assign right     = lb_rd_data[PIXEL_W-1:0];

    // Window of the two previous columns, shifted as each pixel moves on.
    window_t win_reg, win_next;

    always_comb begin
        win_next    = win_reg;
        win_next[0] = win_reg[3];
        win_next[1] = win_reg[4];
        win_next[2] = win_reg[5];
        win_next[3] = top_right;
        win_next[4] = right;
        win_next[5] = s1_pixel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_advance) begin
            win_reg <= win_next;
        end
    end

    // Pattern compare and label lookup.
    logic [CODE_W-1:0] code_calc;

    lbp_pattern_unit u_pattern_unit (
        .window       (win_reg),
        .top_right    (top_right),
        .right        (right),
        .bottom_right (s1_pixel_reg),
        .uniform_mode (uniform_mode_reg),
        .code         (code_calc)
    );

    // Result register.
    logic     m_valid_next;
    lbp_out_t m_data_reg;

    assign m_valid_next = s1_advance ? s1_produce_reg : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_produce_reg) begin
            m_data_reg.code    <= code_calc;
            m_data_reg.row_end <= s1_row_end_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The column counter stays inside the line buffer.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(column_count_reg) < EW'(MAX_WIDTH))
        else $error("column count beyond line buffer depth");

    // The row count saturates at two.
    a_rows_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_seen_reg <= 2'd2)
        else $error("row count above two");

    // A result is only scheduled for an interior column.
    a_produce_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_produce_reg) |-> (s1_col_reg >= CW'(2)))
        else $error("result scheduled on a border column");

    // A pixel held behind a stalled result is not dropped.
    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |=> s1_valid_reg)
        else $error("input stage lost a pixel during a stall");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lbp_pkg::*;

    localparam int LBP_MAX_WIDTH = 2048;
    // The block has a two-stage pipeline; a few spare cycles cover any pixel in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // Unused register slots; writes to them must leave the block unchanged.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [CODE_W-1:0] PAT_ALL_SET       = 8'hFF;
    localparam logic [CODE_W-1:0] PAT_NONE_SET      = 8'h00;
    localparam logic [CODE_W-1:0] LABEL_NON_UNIFORM = 8'd0;
    localparam logic [CODE_W-1:0] LABEL_ALL_SET     = 8'd58;

    typedef enum int {PIX_NOISE, PIX_RAMP, PIX_BINARY, PIX_FLAT} pix_style_t;

    typedef struct packed {
        logic               uniform;
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
        logic               pinned;
        logic [CODE_W-1:0]  code;
        logic               row_end;
    } directed_row_t;

    // Two 3-pixel-wide frames of four rows each. The first runs in raw mode:
    // a flat field where every neighbor ties with the center, then a bright
    // center over a dark surround. The second runs in uniform mode: an
    // alternating ring, then a dark center.
    localparam directed_row_t DIRECTED_ROWS [24] = '{
        '{1'b0, 8'd0,   1'b1, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd255, 1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b1, PAT_ALL_SET,       1'b1},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b0, PAT_NONE_SET,      1'b0},
        '{1'b0, 8'd0,   1'b0, 1'b1, PAT_NONE_SET,      1'b1},
        '{1'b1, 8'd255, 1'b1, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd0,   1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd255, 1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd0,   1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd128, 1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd0,   1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd255, 1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd0,   1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd255, 1'b0, 1'b1, LABEL_NON_UNIFORM, 1'b1},
        '{1'b1, 8'd0,   1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd0,   1'b0, 1'b0, LABEL_NON_UNIFORM, 1'b0},
        '{1'b1, 8'd0,   1'b0, 1'b1, LABEL_ALL_SET,     1'b1}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    lbp_in_t                s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    lbp_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow of the block: line stores, window, position and registers.
    logic [PIXEL_W-1:0]      line_two_up [LBP_MAX_WIDTH];
    logic [PIXEL_W-1:0]      line_one_up [LBP_MAX_WIDTH];
    window_t                 nbhd_cols;
    int                      col_pos;
    int                      rows_filled;
    logic [LINE_WIDTH_W-1:0] width_reg;
    logic                    uniform_reg;
    logic [CODE_W-1:0]       uniform_label [256];

    lbp_out_t pending_codes [$];
    bit       pin_on = 1'b0;
    lbp_out_t pin_code = '0;
    int       tx_idle_pct = 11;
    int       rx_idle_pct = 77;
    int       pixels_sent = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    lbp_3x3_uniform_coder #(.MAX_WIDTH(LBP_MAX_WIDTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The result side stalls at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic int clamp_width(input logic [LINE_WIDTH_W-1:0] value);
        if (value < 3)
            return 3;
        if (value > LBP_MAX_WIDTH)
            return LBP_MAX_WIDTH;
        return int'(value);
    endfunction

    // Advances the shadow by one pixel and computes the code it completes, if any.
    task automatic predict_lbp_code(input lbp_in_t item, output bit emits,
                                    output lbp_out_t res);
        int                 w;
        int                 col;
        logic [PIXEL_W-1:0] above_next;
        logic [PIXEL_W-1:0] beside_next;
        logic [PIXEL_W-1:0] ring [8];
        logic [7:0]         pattern;
        w     = clamp_width(width_reg);
        emits = 1'b0;
        res   = '0;
        if (item.frame_start) begin
            col_pos     = 0;
            rows_filled = 0;
        end
        // A column past a narrowed line starts a new row.
        col = col_pos;
        if (col >= w) begin
            col = 0;
            if (rows_filled < 2)
                rows_filled++;
        end
        above_next  = line_two_up[col];
        beside_next = line_one_up[col];

        // Neighbors run clockwise from top-left; each sets its bit when not below center.
        if (rows_filled == 2 && col >= 2) begin
            ring[0] = nbhd_cols[0];
            ring[1] = nbhd_cols[3];
            ring[2] = above_next;
            ring[3] = beside_next;
            ring[4] = item.pixel;
            ring[5] = nbhd_cols[5];
            ring[6] = nbhd_cols[2];
            ring[7] = nbhd_cols[1];
            for (int k = 0; k < 8; k++)
                pattern[k] = (ring[k] >= nbhd_cols[4]);
            res.code    = uniform_reg ? uniform_label[pattern] : pattern;
            res.row_end = (col == w - 1);
            emits       = 1'b1;
        end

        nbhd_cols[0] = nbhd_cols[3];
        nbhd_cols[1] = nbhd_cols[4];
        nbhd_cols[2] = nbhd_cols[5];
        nbhd_cols[3] = above_next;
        nbhd_cols[4] = beside_next;
        nbhd_cols[5] = item.pixel;
        line_two_up[col] = beside_next;
        line_one_up[col] = item.pixel;

        if (col + 1 >= w) begin
            col_pos = 0;
            if (rows_filled < 2)
                rows_filled++;
        end else begin
            col_pos = col + 1;
        end
    endtask

    // Checks each result transfer, then tracks register writes and pixel transfers.
    always @(posedge aclk) begin : scoreboard
        lbp_out_t want;
        lbp_out_t predicted;
        bit       emits;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_codes.size() == 0) begin
                    $error("code: nothing expected, got %0d (row_end %0b)",
                           m_data.code, m_data.row_end);
                    error_count++;
                end else begin
                    want = pending_codes.pop_front();
                    if (m_data.code !== want.code) begin
                        $error("code: expected %0d, got %0d", want.code, m_data.code);
                        error_count++;
                    end
                    if (m_data.row_end !== want.row_end) begin
                        $error("row_end: expected %0b, got %0b", want.row_end, m_data.row_end);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LINE_WIDTH:   width_reg = cfg_data[LINE_WIDTH_W-1:0];
                    REG_UNIFORM_MODE: uniform_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_lbp_code(s_data, emits, predicted);
                if (pin_on)
                    pending_codes.push_back(pin_code);
                else if (emits)
                    pending_codes.push_back(predicted);
            end
        end
    end

    // Offers one pixel, with random idle cycles first, and waits for its transfer.
    task automatic send_pixel(input lbp_in_t item, input bit pinned, input lbp_out_t pinned_code);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_data   = item;
        pin_on   = pinned;
        pin_code = pinned_code;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Stops the pixel stream until every code is out and the pipeline is empty.
    task automatic drain_and_settle();
        s_valid = 1'b0;
        while (pending_codes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Sends a run of pixels of one random texture, with stray frame starts when noisy.
    task automatic send_frame(input int count, input bit open_frame, input bit noisy);
        pix_style_t style;
        int         base;
        int         slope;
        lbp_in_t    item;
        style = pix_style_t'($urandom_range(3));
        base  = $urandom_range(255);
        slope = int'($urandom_range(6)) - 3;
        for (int k = 0; k < count; k++) begin
            case (style)
                PIX_NOISE:  item.pixel = PIXEL_W'($urandom_range(255));
                PIX_RAMP:   item.pixel = PIXEL_W'(base + slope * k + int'($urandom_range(2)));
                PIX_BINARY: item.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
                default:    item.pixel = PIXEL_W'(base + int'($urandom_range(1)));
            endcase
            item.frame_start = (k == 0 && open_frame) || (noisy && $urandom_range(199) == 0);
            send_pixel(item, 1'b0, '0);
        end
    endtask

    // Frames of random small widths. The line only widens at a new frame, so
    // no unwritten line-store entry is ever read back.
    task automatic run_random_frames(input int tx_pct, input int rx_pct, input int budget);
        int first;
        int w_new;
        int w_cur;
        int count;
        int cut;
        bit grow;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first = pixels_sent;
        while (pixels_sent - first < budget) begin
            drain_and_settle();
            case ($urandom_range(9))
                0:       w_new = $urandom_range(2);
                1:       w_new = 3;
                2:       w_new = $urandom_range(25, 100);
                default: w_new = $urandom_range(3, 24);
            endcase
            grow = clamp_width(LINE_WIDTH_W'(w_new)) > clamp_width(width_reg);
            if (grow || $urandom_range(3) != 0)
                write_reg(REG_LINE_WIDTH, CFG_DATA_W'(w_new));
            if ($urandom_range(2) == 0)
                write_reg(REG_UNIFORM_MODE, CFG_DATA_W'($urandom));
            w_cur = clamp_width(width_reg);
            count = int'($urandom_range(3, 6)) * w_cur;
            if ($urandom_range(4) == 0)
                count -= int'($urandom_range(1, w_cur));
            if (w_cur > 3 && $urandom_range(6) == 0) begin
                // Narrow the line partway through a row and carry on in the same frame.
                cut = $urandom_range(1, count - 1);
                send_frame(cut, 1'b1, 1'b0);
                drain_and_settle();
                write_reg(REG_LINE_WIDTH, CFG_DATA_W'($urandom_range(3, w_cur - 1)));
                send_frame(count - cut, 1'b0, 1'b1);
            end else begin
                send_frame(count, grow || $urandom_range(5) != 0, 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        int         rank;
        int         flips;
        logic [7:0] pat;
        lbp_in_t    dir_item;
        lbp_out_t   dir_code;

        // Uniform labels: patterns with at most two circular flips, ranked in order.
        rank = 1;
        for (int v = 0; v < 256; v++) begin
            pat   = 8'(v);
            flips = 0;
            for (int k = 0; k < 8; k++)
                if (pat[k] != pat[(k + 1) % 8])
                    flips++;
            if (flips <= 2) begin
                uniform_label[v] = CODE_W'(rank);
                rank++;
            end else begin
                uniform_label[v] = '0;
            end
        end
        width_reg   = LINE_WIDTH_RESET;
        uniform_reg = UNIFORM_MODE_RESET;
        nbhd_cols   = '0;
        col_pos     = 0;
        rows_filled = 0;
        for (int i = 0; i < LBP_MAX_WIDTH; i++) begin
            line_two_up[i] = '0;
            line_one_up[i] = '0;
        end

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed frames on a width below the legal range, which clamps to three.
        write_reg(REG_LINE_WIDTH, '0);
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].uniform != uniform_reg) begin
                drain_and_settle();
                write_reg(REG_UNIFORM_MODE, {11'($urandom), DIRECTED_ROWS[i].uniform});
            end
            dir_item.pixel       = DIRECTED_ROWS[i].pixel;
            dir_item.frame_start = DIRECTED_ROWS[i].frame_start;
            dir_code.code        = DIRECTED_ROWS[i].code;
            dir_code.row_end     = DIRECTED_ROWS[i].row_end;
            send_pixel(dir_item, DIRECTED_ROWS[i].pinned, dir_code);
        end

        // Sender mostly busy, receiver mostly stalled; a short run on the widest
        // line, too short to complete a neighborhood, must give no result.
        run_random_frames(11, 77, 480);
        drain_and_settle();
        write_reg(REG_LINE_WIDTH, CFG_DATA_W'(LBP_MAX_WIDTH));
        send_frame(48, 1'b1, 1'b0);

        // Sender mostly idle, receiver mostly ready.
        run_random_frames(77, 11, 480);

        // Full rate; a width above the range clamps to the widest line.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_and_settle();
        write_reg(REG_LINE_WIDTH, '1);
        send_frame(48, 1'b1, 1'b0);
        run_random_frames(0, 0, 480);

        drain_and_settle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== lbp_3x3_uniform_coder.f =====
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_line_buffer.sv
hw/rtl/lbp_pattern_unit.sv
hw/rtl/lbp_3x3_uniform_coder.sv
bench/tb.sv
